[design/ddo_pkg.sv]
package ddo_pkg;

    // shared multiplier operand and result widths, accumulator and delta widths
    localparam int A_W   = 34;
    localparam int B_W   = 17;
    localparam int P_W   = A_W + B_W;
    localparam int ACC_W = P_W + 16;
    localparam int DX_W  = 34;

    localparam logic [0:0] REG_TRAVEL_PER_DEGREE = 1'b0;
    localparam logic [0:0] REG_TURN_PER_INCH     = 1'b1;

    localparam logic [15:0] TRAVEL_PER_DEGREE_RST = 16'd2287;
    localparam logic [30:0] TURN_PER_INCH_RST     = 31'd97652182;

    localparam logic signed [A_W-1:0] CORDIC_GAIN = A_W'(652032874);

    localparam logic [29:0] ATAN_TABLE [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21419999,  30'd10745374,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = -ACC_W'(64'sd2147483648);
        if (v > hi)
        begin
            return 32'sh7fffffff;
        end
        else if (v < lo)
        begin
            return 32'sh80000000;
        end
        else
        begin
            return v[31:0];
        end
    endfunction

endpackage

[design/ddo_mul.sv]
module ddo_mul
    import ddo_pkg::*;
(
    input  logic                  clk,
    input  logic signed [A_W-1:0] a,
    input  logic signed [B_W-1:0] b,
    output logic signed [P_W-1:0] prod
);

    logic signed [P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

[design/differential_drive_odometry.sv]
// channel | dir | width | fields (low bit first)
// s       | in  | 64    | left_position[31:0], right_position[31:0]
// m       | out | 96    | x_position[31:0], y_position[31:0], heading[31:0]
// cfg     | in  | 31    | index 0 travel_per_degree, index 1 turn_per_inch
//
// The result is computed by the one-step-per-cycle CORDIC and eight passes
// through the shared 34x17 multiplier. A new sample is not taken until the last
// one is through. s_tready is high only between samples.
// A finished result waits in the output register; a new sample is taken
// meanwhile, and the next result waits until that one is transferred.
// Reset clears position, heading and previous angles and loads register defaults.
module differential_drive_odometry
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // left_position, right_position
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // x_position, y_position, heading
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    localparam int STEP_W = ($clog2(CORDIC_STEPS + 1) > 5) ? $clog2(CORDIC_STEPS + 1) : 5;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_MUL_L  = 5'd1;
    localparam logic [4:0] S_MUL_R  = 5'd2;
    localparam logic [4:0] S_SAT_R  = 5'd3;
    localparam logic [4:0] S_CEN    = 5'd4;
    localparam logic [4:0] S_CORDIC = 5'd5;
    localparam logic [4:0] S_FIX    = 5'd6;
    localparam logic [4:0] S_MXH    = 5'd7;
    localparam logic [4:0] S_MXL    = 5'd8;
    localparam logic [4:0] S_MYH    = 5'd9;
    localparam logic [4:0] S_MYL    = 5'd10;
    localparam logic [4:0] S_MTH    = 5'd11;
    localparam logic [4:0] S_MTL    = 5'd12;
    localparam logic [4:0] S_TADD   = 5'd13;
    localparam logic [4:0] S_HEAD   = 5'd14;
    localparam logic [4:0] S_DONE   = 5'd15;

    logic [4:0]  state_reg;
    logic [4:0]  state_next;
    logic        out_valid_reg;
    logic [15:0] tpd_reg;
    logic [30:0] tpi_reg;
    logic [31:0] last_l_reg;
    logic [31:0] last_r_reg;
    logic [31:0] heading_acc_reg;
    logic signed [31:0] x_acc_reg;
    logic signed [31:0] y_acc_reg;
    logic [STEP_W-1:0]  step_reg;

    logic signed [A_W-1:0]   dl_reg;
    logic signed [A_W-1:0]   dr_reg;
    logic signed [31:0]      tl_reg;
    logic signed [31:0]      tr_reg;
    logic signed [31:0]      centre_reg;
    logic signed [A_W-1:0]   diff_reg;
    logic signed [A_W-1:0]   cx_reg;
    logic signed [A_W-1:0]   cy_reg;
    logic signed [A_W-1:0]   cz_reg;
    logic                    flip_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [DX_W-1:0]  dx_reg;
    logic signed [DX_W-1:0]  dy_reg;
    logic [31:0] x_out_reg;
    logic [31:0] y_out_reg;
    logic [31:0] h_out_reg;

    logic signed [A_W-1:0]   mul_a;
    logic signed [B_W-1:0]   mul_b;
    logic signed [P_W-1:0]   prod;
    logic                    in_xfer;
    logic                    flip;
    logic signed [A_W-1:0]   xs;
    logic signed [A_W-1:0]   ys;
    logic signed [A_W-1:0]   atan;
    logic signed [ACC_W-1:0] prod_sh;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [32:0]      tsum;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {h_out_reg, y_out_reg, x_out_reg};

    assign flip    = heading_acc_reg[31] ^ heading_acc_reg[30];
    assign xs      = cx_reg >>> step_reg[4:0];
    assign ys      = cy_reg >>> step_reg[4:0];
    assign atan    = $signed({{(A_W-30){1'b0}}, ATAN_TABLE[step_reg[4:0]]});
    assign prod_sh = $signed({prod, 16'b0});
    assign acc_rnd = acc_reg + $signed({{(ACC_W-30){1'b0}}, 1'b1, 29'b0});
    assign tsum    = $signed({tl_reg[31], tl_reg}) + $signed({tr_reg[31], tr_reg});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL_L:
            begin
                mul_a = dl_reg;
                mul_b = $signed({1'b0, tpd_reg});
            end
            S_MUL_R:
            begin
                mul_a = dr_reg;
                mul_b = $signed({1'b0, tpd_reg});
            end
            S_MXH:
            begin
                mul_a = cy_reg;
                mul_b = $signed({centre_reg[31], centre_reg[31:16]});
            end
            S_MXL:
            begin
                mul_a = cy_reg;
                mul_b = $signed({1'b0, centre_reg[15:0]});
            end
            S_MYH:
            begin
                mul_a = cx_reg;
                mul_b = $signed({centre_reg[31], centre_reg[31:16]});
            end
            S_MYL:
            begin
                mul_a = cx_reg;
                mul_b = $signed({1'b0, centre_reg[15:0]});
            end
            S_MTH:
            begin
                mul_a = diff_reg;
                mul_b = $signed({2'b0, tpi_reg[30:16]});
            end
            S_MTL:
            begin
                mul_a = diff_reg;
                mul_b = $signed({1'b0, tpi_reg[15:0]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ddo_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_xfer) state_next = S_MUL_L;
            S_MUL_L:  state_next = S_MUL_R;
            S_MUL_R:  state_next = S_SAT_R;
            S_SAT_R:  state_next = S_CEN;
            S_CEN:    state_next = S_CORDIC;
            S_CORDIC: if (step_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = S_FIX;
            S_FIX:    state_next = S_MXH;
            S_MXH:    state_next = S_MXL;
            S_MXL:    state_next = S_MYH;
            S_MYH:    state_next = S_MYL;
            S_MYL:    state_next = S_MTH;
            S_MTH:    state_next = S_MTL;
            S_MTL:    state_next = S_TADD;
            S_TADD:   state_next = S_HEAD;
            S_HEAD:   state_next = S_DONE;
            S_DONE:   if (!out_valid_reg || m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            tpd_reg         <= TRAVEL_PER_DEGREE_RST;
            tpi_reg         <= TURN_PER_INCH_RST;
            last_l_reg      <= '0;
            last_r_reg      <= '0;
            heading_acc_reg <= '0;
            x_acc_reg       <= '0;
            y_acc_reg       <= '0;
            step_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TRAVEL_PER_DEGREE: tpd_reg <= cfg_data[15:0];
                    REG_TURN_PER_INCH:     tpi_reg <= cfg_data;
                    default:               tpd_reg <= tpd_reg;
                endcase
            end
            if (in_xfer)
            begin
                last_l_reg <= s_tdata[31:0];
                last_r_reg <= s_tdata[63:32];
                step_reg   <= '0;
            end
            if (state_reg == S_CORDIC)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (state_reg == S_MTH)
            begin
                x_acc_reg <= sat32(ACC_W'(x_acc_reg) + ACC_W'(dx_reg));
            end
            if (state_reg == S_TADD)
            begin
                y_acc_reg <= sat32(ACC_W'(y_acc_reg) + ACC_W'(dy_reg));
            end
            if (state_reg == S_HEAD)
            begin
                heading_acc_reg <= heading_acc_reg + acc_reg[47:16];
            end
            if (state_reg == S_DONE && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            dl_reg   <= A_W'($signed({s_tdata[31], s_tdata[31:0]})
                           - $signed({last_l_reg[31], last_l_reg}));
            dr_reg   <= A_W'($signed({s_tdata[63], s_tdata[63:32]})
                           - $signed({last_r_reg[31], last_r_reg}));
            flip_reg <= flip;
            cx_reg   <= CORDIC_GAIN;
            cy_reg   <= '0;
            cz_reg   <= A_W'($signed({heading_acc_reg[31] ^ flip, heading_acc_reg[30:0]}));
        end
        unique case (state_reg)
            S_MUL_R:
            begin
                tl_reg <= sat32(ACC_W'(prod));
            end
            S_SAT_R:
            begin
                tr_reg <= sat32(ACC_W'(prod));
            end
            S_CEN:
            begin
                centre_reg <= tsum[32:1];
                diff_reg   <= A_W'($signed({tr_reg[31], tr_reg})
                               - $signed({tl_reg[31], tl_reg}));
            end
            S_CORDIC:
            begin
                if (!cz_reg[A_W-1])
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan;
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan;
                end
            end
            S_FIX:
            begin
                // cx becomes cos, cy becomes -sin
                cx_reg <= flip_reg ? -cx_reg : cx_reg;
                cy_reg <= flip_reg ? cy_reg : -cy_reg;
            end
            S_MXL, S_MTL:
            begin
                acc_reg <= prod_sh;
                if (state_reg == S_MTL)
                begin
                    dy_reg <= acc_rnd[30 +: DX_W];
                end
            end
            S_MYL:
            begin
                acc_reg <= prod_sh;
                dx_reg  <= acc_rnd[30 +: DX_W];
            end
            S_MYH, S_MTH, S_TADD:
            begin
                acc_reg <= acc_reg + ACC_W'(prod);
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    x_out_reg <= x_acc_reg;
                    y_out_reg <= y_acc_reg;
                    h_out_reg <= heading_acc_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CORDIC |-> step_reg < STEP_W'(CORDIC_STEPS))
        else $error("cordic step out of range");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside done");

    a_heading_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_HEAD |=> $stable(heading_acc_reg))
        else $error("heading changed outside update");

endmodule
